// ===== rtl/core/grid_point_isometric_projector_assert.svh =====
// assertion macros for the isometric projector
`ifndef GRID_POINT_ISOMETRIC_PROJECTOR_ASSERT_SVH
`define GRID_POINT_ISOMETRIC_PROJECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GPIP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gpip same-cycle check failed");

// next-cycle implication, checked outside reset
`define GPIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gpip next-cycle check failed");

`endif

// ===== rtl/core/gpip_pkg.sv =====
// shared types, widths and register codes of the isometric projector
`default_nettype none

package gpip_pkg;

    // field widths
    localparam int GRID_BITS  = 10;
    localparam int COORD_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ISO      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE = 4'd7;

    // reset values: cos 1.0 / sin 0, iso 30 degrees, unity gains
    localparam logic [31:0] ROT_RESET   = 32'h4000_0000;
    localparam logic [31:0] ISO_RESET   = 32'h376D_2000;
    localparam logic [15:0] DEPTH_RESET = 16'h1000;
    localparam logic [15:0] ZOOM_RESET  = 16'h0100;

    // datapath widths, all signed
    // centring term 2*col - (w-1)
    localparam int CTR_W   = (GRID_BITS + 2 > 12) ? GRID_BITS + 2 : 12;
    // scaled x / y in Q12
    localparam int XY0_W   = CTR_W + 19;
    // common width entering the x rotation
    localparam int R0_W    = (XY0_W > 32) ? XY0_W : 32;
    // each rotation grows the magnitude by at most two bits
    localparam int RX_W    = R0_W + 2;
    localparam int RY_W    = RX_W + 2;
    localparam int RZ_W    = RY_W + 2;
    // isometric difference / sum, products and floored results
    localparam int ISO_D_W = RZ_W + 1;
    localparam int ISO_P_W = ISO_D_W + 16;
    localparam int ISO_W   = ISO_P_W - 13;
    // second zoom product and shifted sum in Q20
    localparam int ZM_W    = ISO_W + 17;
    localparam int SH_W    = ZM_W + 1;
    localparam int Q_W     = SH_W - 20;

    typedef struct packed {
        logic        [GRID_BITS-1:0] grid_col;
        logic        [GRID_BITS-1:0] grid_row;
        logic signed [15:0]          height;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] screen_x;
        logic signed [COORD_BITS-1:0] screen_y;
        logic                         clipped;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/gpip_front.sv =====
// front stages: map centring, first zoom and height scaling
`default_nettype none

module gpip_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_vld,
    input  gpip_pkg::t_in_item                    i_item,
    input  logic [21:0]                           i_map_size,
    input  logic [15:0]                           i_zoom,
    input  logic signed [15:0]                    i_depth,
    output logic                                  o_vld,
    output logic signed [gpip_pkg::R0_W-1:0]      o_x0,
    output logic signed [gpip_pkg::R0_W-1:0]      o_y0,
    output logic signed [gpip_pkg::R0_W-1:0]      o_z0
);

    localparam int CTR_W = gpip_pkg::CTR_W;
    localparam int XY0_W = gpip_pkg::XY0_W;
    localparam int R0_W  = gpip_pkg::R0_W;

    logic signed [CTR_W-1:0]  n_ax, n_ay;
    logic signed [31:0]       n_z;
    logic signed [CTR_W-1:0]  r_ax, r_ay;
    logic signed [31:0]       r_z;
    logic                     r_vld1;

    logic signed [16:0]       w_zoom_s;
    logic signed [CTR_W+16:0] w_px, w_py;
    logic signed [XY0_W-1:0]  n_x0, n_y0;
    logic signed [R0_W-1:0]   r_x0, r_y0, r_z0;
    logic                     r_vld2;

    // stage 1: centring term and height times depth gain
    always_comb begin
        n_ax = CTR_W'({i_item.grid_col, 1'b0})
             - (CTR_W'(i_map_size[21:11]) - CTR_W'(1));
        n_ay = CTR_W'({i_item.grid_row, 1'b0})
             - (CTR_W'(i_map_size[10:0]) - CTR_W'(1));
        n_z  = i_item.height * i_depth;
    end

    // stage 2: zoom, then Q9 to Q12
    assign w_zoom_s = {1'b0, i_zoom};

    always_comb begin
        w_px = r_ax * w_zoom_s;
        w_py = r_ay * w_zoom_s;
        n_x0 = {w_px[CTR_W+15:0], 3'b000};
        n_y0 = {w_py[CTR_W+15:0], 3'b000};
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_z  <= n_z;
            r_x0 <= R0_W'(n_x0);
            r_y0 <= R0_W'(n_y0);
            r_z0 <= R0_W'(r_z);
        end
    end

    assign o_vld = r_vld2;
    assign o_x0  = r_x0;
    assign o_y0  = r_y0;
    assign o_z0  = r_z0;

endmodule

`default_nettype wire

// ===== rtl/core/gpip_rot.sv =====
// one plane rotation: a = u*c - v*s, b = u*s + v*c, both floored by 14 bits
`default_nettype none

module gpip_rot #(
    parameter int IN_W   = 32,
    parameter int PASS_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_vld,
    input  logic signed [IN_W-1:0]   i_u,
    input  logic signed [IN_W-1:0]   i_v,
    input  logic [31:0]              i_trig,
    input  logic signed [PASS_W-1:0] i_pass,
    output logic                     o_vld,
    output logic signed [IN_W+1:0]   o_a,
    output logic signed [IN_W+1:0]   o_b,
    output logic signed [PASS_W-1:0] o_pass
);

    localparam int OUT_W  = IN_W + 2;
    localparam int PROD_W = IN_W + 16;

    logic signed [15:0]       w_c, w_s;
    logic signed [PROD_W-1:0] n_uc, n_vs, n_us, n_vc;
    logic signed [PROD_W-1:0] r_uc, r_vs, r_us, r_vc;
    logic signed [PASS_W-1:0] r_pass1, r_pass2;
    logic signed [PROD_W:0]   w_sa, w_sb;
    logic signed [OUT_W-1:0]  r_a, r_b;
    logic                     r_vld1, r_vld2;

    assign w_c = i_trig[31:16];
    assign w_s = i_trig[15:0];

    // stage 1: four products
    always_comb begin
        n_uc = i_u * w_c;
        n_vs = i_v * w_s;
        n_us = i_u * w_s;
        n_vc = i_v * w_c;
    end

    // stage 2: combine and drop the Q14 fraction (arithmetic shift floors)
    always_comb begin
        w_sa = r_uc - r_vs;
        w_sb = r_us + r_vc;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_uc    <= n_uc;
            r_vs    <= n_vs;
            r_us    <= n_us;
            r_vc    <= n_vc;
            r_pass1 <= i_pass;
            r_a     <= w_sa[OUT_W+13:14];
            r_b     <= w_sb[OUT_W+13:14];
            r_pass2 <= r_pass1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_pass = r_pass2;

endmodule

`default_nettype wire

// ===== rtl/core/gpip_back.sv =====
// back stages: isometric projection, second zoom, screen shift, saturation
`default_nettype none

module gpip_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_vld,
    input  logic signed [gpip_pkg::RZ_W-1:0]    i_x3,
    input  logic signed [gpip_pkg::RZ_W-1:0]    i_y3,
    input  logic signed [gpip_pkg::RY_W-1:0]    i_z2,
    input  logic [31:0]                         i_iso,
    input  logic [15:0]                         i_zoom,
    input  logic [31:0]                         i_shift,
    output logic                                o_vld,
    output gpip_pkg::t_out_item                 o_item
);

    localparam int RY_W    = gpip_pkg::RY_W;
    localparam int ISO_D_W = gpip_pkg::ISO_D_W;
    localparam int ISO_P_W = gpip_pkg::ISO_P_W;
    localparam int ISO_W   = gpip_pkg::ISO_W;
    localparam int ZM_W    = gpip_pkg::ZM_W;
    localparam int SH_W    = gpip_pkg::SH_W;
    localparam int Q_W     = gpip_pkg::Q_W;
    localparam int CB      = gpip_pkg::COORD_BITS;
    localparam int NSTAGE  = 6;

    // truncate Q20 toward zero and clamp; returns {clip, coordinate}
    function automatic logic [CB:0] sat_coord(input logic signed [SH_W-1:0] v);
        logic signed [Q_W-1:0] q;
        logic signed [Q_W-1:0] hi;
        logic signed [Q_W-1:0] lo;
        q  = v[SH_W-1:20];
        hi = Q_W'((2 ** (CB - 1)) - 1);
        lo = -hi - Q_W'(1);
        if (v[SH_W-1] && (|v[19:0])) begin
            q = q + Q_W'(1);
        end
        if (q > hi) begin
            sat_coord = {1'b1, hi[CB-1:0]};
        end else if (q < lo) begin
            sat_coord = {1'b1, lo[CB-1:0]};
        end else begin
            sat_coord = {1'b0, q[CB-1:0]};
        end
    endfunction

    logic signed [15:0]        w_ci, w_si;
    logic signed [16:0]        w_zoom_s;
    logic signed [35:0]        w_shx, w_shy;

    logic signed [ISO_D_W-1:0] r_dx, r_dy;
    logic signed [RY_W-1:0]    r_za, r_zb;
    logic signed [ISO_P_W-1:0] n_px, n_py, r_px, r_py;
    logic signed [ISO_W-2:0]   w_hx, w_hy;
    logic signed [ISO_W-1:0]   r_ix, r_iy;
    logic signed [ZM_W-1:0]    n_mx, n_my, r_mx, r_my;
    logic signed [SH_W-1:0]    r_sx, r_sy;
    logic [CB:0]               w_satx, w_saty;
    gpip_pkg::t_out_item       r_out;
    logic [NSTAGE-1:0]         r_vld;

    assign w_ci     = i_iso[31:16];
    assign w_si     = i_iso[15:0];
    assign w_zoom_s = {1'b0, i_zoom};
    assign w_shx    = {i_shift[31:16], 20'h00000};
    assign w_shy    = {i_shift[15:0], 20'h00000};

    // products of the isometric step and of the second zoom
    always_comb begin
        n_px = r_dx * w_ci;
        n_py = r_dy * w_si;
        n_mx = r_ix * w_zoom_s;
        n_my = r_iy * w_zoom_s;
    end

    // floor by 14 bits; the height term is a whole multiple of 2^14
    assign w_hx = r_px[ISO_P_W-1:14];
    assign w_hy = r_py[ISO_P_W-1:14];

    assign w_satx = sat_coord(r_sx);
    assign w_saty = sat_coord(r_sy);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NSTAGE-2:0], i_vld};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx           <= ISO_D_W'(i_x3) - ISO_D_W'(i_y3);
            r_dy           <= ISO_D_W'(i_x3) + ISO_D_W'(i_y3);
            r_za           <= i_z2;
            r_px           <= n_px;
            r_py           <= n_py;
            r_zb           <= r_za;
            r_ix           <= ISO_W'(w_hx);
            r_iy           <= ISO_W'(w_hy) - ISO_W'(r_zb);
            r_mx           <= n_mx;
            r_my           <= n_my;
            r_sx           <= SH_W'(r_mx) + SH_W'(w_shx);
            r_sy           <= SH_W'(r_my) + SH_W'(w_shy);
            r_out.screen_x <= w_satx[CB-1:0];
            r_out.screen_y <= w_saty[CB-1:0];
            r_out.clipped  <= w_satx[CB] | w_saty[CB];
        end
    end

    assign o_vld  = r_vld[NSTAGE-1];
    assign o_item = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/grid_point_isometric_projector.sv =====
// top level of the isometric projector: registers, rotation chain, flow control
`default_nettype none

// Projects map points (column, row, height) to screen coordinates. One point
// is accepted every clock while no finished result is held by a stall; it
// passes 2 front stages, 2 stages for each of the three rotations and 6
// stages for projection, zoom, shift and saturation, the last being the
// output register. When the output is valid and stalled, every stage holds,
// so the input stalls in the same cycle. Registers are written through the
// cfg channel, which is always ready; write them only while no point is in
// flight. Indexes beyond the register list are ignored.

`include "grid_point_isometric_projector_assert.svh"

module grid_point_isometric_projector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  gpip_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output gpip_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gpip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gpip_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int R0_W = gpip_pkg::R0_W;
    localparam int RX_W = gpip_pkg::RX_W;
    localparam int RY_W = gpip_pkg::RY_W;
    localparam int RZ_W = gpip_pkg::RZ_W;

    // configuration registers
    logic [31:0]        r_rot_x, r_rot_y, r_rot_z, r_iso, r_shift;
    logic signed [15:0] r_depth;
    logic [15:0]        r_zoom;
    logic [21:0]        r_map_size;

    logic                   w_adv;
    logic                   w_zoom_wr;
    logic                   w_f_vld, w_x_vld, w_y_vld, w_z_vld;
    logic signed [R0_W-1:0] w_x0, w_y0, w_z0, w_xp;
    logic signed [RX_W-1:0] w_y1, w_z1, w_yp;
    logic signed [RY_W-1:0] w_x2, w_z2, w_zp;
    logic signed [RZ_W-1:0] w_x3, w_y3;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x    <= gpip_pkg::ROT_RESET;
            r_rot_y    <= gpip_pkg::ROT_RESET;
            r_rot_z    <= gpip_pkg::ROT_RESET;
            r_iso      <= gpip_pkg::ISO_RESET;
            r_depth    <= gpip_pkg::DEPTH_RESET;
            r_zoom     <= gpip_pkg::ZOOM_RESET;
            r_shift    <= '0;
            r_map_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                gpip_pkg::CFG_ROT_X:    r_rot_x    <= i_cfg_data;
                gpip_pkg::CFG_ROT_Y:    r_rot_y    <= i_cfg_data;
                gpip_pkg::CFG_ROT_Z:    r_rot_z    <= i_cfg_data;
                gpip_pkg::CFG_ISO:      r_iso      <= i_cfg_data;
                gpip_pkg::CFG_DEPTH:    r_depth    <= i_cfg_data[15:0];
                gpip_pkg::CFG_ZOOM:     r_zoom     <= i_cfg_data[15:0];
                gpip_pkg::CFG_SHIFT:    r_shift    <= i_cfg_data;
                gpip_pkg::CFG_MAP_SIZE: r_map_size <= i_cfg_data[21:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // zoom register write transfer
    assign w_zoom_wr = i_cfg_valid && o_cfg_ready && (i_cfg_index == gpip_pkg::CFG_ZOOM);

    // whole pipeline moves unless a finished result is waiting on a stall
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    gpip_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_vld      (i_valid),
        .i_item     (i_data),
        .i_map_size (r_map_size),
        .i_zoom     (r_zoom),
        .i_depth    (r_depth),
        .o_vld      (w_f_vld),
        .o_x0       (w_x0),
        .o_y0       (w_y0),
        .o_z0       (w_z0)
    );

    // x axis: y1 = y*c - z*s, z1 = y*s + z*c
    gpip_rot #(
        .IN_W   (R0_W),
        .PASS_W (R0_W)
    ) u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_f_vld),
        .i_u     (w_y0),
        .i_v     (w_z0),
        .i_trig  (r_rot_x),
        .i_pass  (w_x0),
        .o_vld   (w_x_vld),
        .o_a     (w_y1),
        .o_b     (w_z1),
        .o_pass  (w_xp)
    );

    // y axis: z2 = z*c - x*s, x2 = z*s + x*c
    gpip_rot #(
        .IN_W   (RX_W),
        .PASS_W (RX_W)
    ) u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_x_vld),
        .i_u     (w_z1),
        .i_v     (RX_W'(w_xp)),
        .i_trig  (r_rot_y),
        .i_pass  (w_y1),
        .o_vld   (w_y_vld),
        .o_a     (w_z2),
        .o_b     (w_x2),
        .o_pass  (w_yp)
    );

    // z axis: x3 = x*c - y*s, y3 = x*s + y*c
    gpip_rot #(
        .IN_W   (RY_W),
        .PASS_W (RY_W)
    ) u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_y_vld),
        .i_u     (w_x2),
        .i_v     (RY_W'(w_yp)),
        .i_trig  (r_rot_z),
        .i_pass  (w_z2),
        .o_vld   (w_z_vld),
        .o_a     (w_x3),
        .o_b     (w_y3),
        .o_pass  (w_zp)
    );

    gpip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_z_vld),
        .i_x3    (w_x3),
        .i_y3    (w_y3),
        .i_z2    (w_zp),
        .i_iso   (r_iso),
        .i_zoom  (r_zoom),
        .i_shift (r_shift),
        .o_vld   (o_valid),
        .o_item  (o_data)
    );

    // checks
    `GPIP_ASSERT_NEXT(a_stalled_result_held, (o_valid && i_stall), (o_valid && $stable(o_data)))
    `GPIP_ASSERT_NEXT(a_held_item_kept, (!w_adv && w_z_vld), w_z_vld)
    `GPIP_ASSERT_IMPLY(a_stall_only_on_waiting_result, o_stall, (o_valid && i_stall))
    `GPIP_ASSERT_NEXT(a_zoom_write_lands, w_zoom_wr, (r_zoom == $past(i_cfg_data[15:0])))

endmodule

`default_nettype wire

// ===== tb/projector_checker.sv =====
// checker for the isometric projector: register copy, screen point prediction, comparison
module projector_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  gpip_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  gpip_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [gpip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gpip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int     CB        = gpip_pkg::COORD_BITS;
    localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // local copy of the register file
    logic [31:0]        rot_x_q;
    logic [31:0]        rot_y_q;
    logic [31:0]        rot_z_q;
    logic [31:0]        iso_q;
    logic signed [15:0] depth_q;
    logic [15:0]        zoom_q;
    logic [31:0]        shift_q;
    logic [21:0]        map_q;

    gpip_pkg::t_out_item expected_screen_q[$];
    gpip_pkg::t_out_item expected_pt;
    int                  fail_cnt    = 0;
    int                  pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic longint trig_cos(input logic [31:0] r);
        return longint'($signed(r[31:16]));
    endfunction

    function automatic longint trig_sin(input logic [31:0] r);
        return longint'($signed(r[15:0]));
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // full projection of one grid point with the current registers
    function automatic gpip_pkg::t_out_item project_point(input gpip_pkg::t_in_item pt);
        longint              col, row, h, dg, zoom, w, hm;
        longint              x, y, z, nx, ny, nz, c, s, sx, sy;
        gpip_pkg::t_out_item res;
        col  = longint'(pt.grid_col);
        row  = longint'(pt.grid_row);
        h    = longint'(pt.height);
        dg   = longint'(depth_q);
        zoom = longint'(zoom_q);
        w    = longint'(map_q[21:11]);
        hm   = longint'(map_q[10:0]);

        // zoom and centre on the map middle, Q12
        x = (2 * col * zoom - (w - 1) * zoom) * 8;
        y = (2 * row * zoom - (hm - 1) * zoom) * 8;
        z = h * dg;

        // rotation about x
        c  = trig_cos(rot_x_q);
        s  = trig_sin(rot_x_q);
        ny = (y * c - z * s) >>> 14;
        nz = (y * s + z * c) >>> 14;
        y  = ny;
        z  = nz;

        // rotation about y
        c  = trig_cos(rot_y_q);
        s  = trig_sin(rot_y_q);
        nx = (x * c + z * s) >>> 14;
        nz = (z * c - x * s) >>> 14;
        x  = nx;
        z  = nz;

        // rotation about z
        c  = trig_cos(rot_z_q);
        s  = trig_sin(rot_z_q);
        nx = (x * c - y * s) >>> 14;
        ny = (x * s + y * c) >>> 14;
        x  = nx;
        y  = ny;

        // isometric projection
        c  = trig_cos(iso_q);
        s  = trig_sin(iso_q);
        nx = ((x - y) * c) >>> 14;
        ny = ((x + y) * s - z * 16384) >>> 14;

        // second zoom and screen shift in Q20, then truncate toward zero
        sx = nx * zoom + trig_cos(shift_q) * 1048576;
        sy = ny * zoom + trig_sin(shift_q) * 1048576;
        sx = sx / 1048576;
        sy = sy / 1048576;

        res.clipped  = (clamp_coord(sx) != sx) || (clamp_coord(sy) != sy);
        sx           = clamp_coord(sx);
        sy           = clamp_coord(sy);
        res.screen_x = sx[CB-1:0];
        res.screen_y = sy[CB-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot_x_q <= gpip_pkg::ROT_RESET;
            rot_y_q <= gpip_pkg::ROT_RESET;
            rot_z_q <= gpip_pkg::ROT_RESET;
            iso_q   <= gpip_pkg::ISO_RESET;
            depth_q <= gpip_pkg::DEPTH_RESET;
            zoom_q  <= gpip_pkg::ZOOM_RESET;
            shift_q <= '0;
            map_q   <= '0;
            expected_screen_q.delete();
        end else begin
            // result transfer against the oldest expected point
            if (i_out_valid && !i_out_stall) begin
                if (expected_screen_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d clipped=%0b", $time,
                             i_out_data.screen_x, i_out_data.screen_y, i_out_data.clipped);
                    fail_cnt++;
                end else begin
                    expected_pt = expected_screen_q.pop_front();
                    if (i_out_data !== expected_pt) begin
                        $display({"%0t: mismatch expected x=%0d y=%0d clipped=%0b, ",
                                  "got x=%0d y=%0d clipped=%0b"},
                                 $time, expected_pt.screen_x, expected_pt.screen_y,
                                 expected_pt.clipped, i_out_data.screen_x,
                                 i_out_data.screen_y, i_out_data.clipped);
                        fail_cnt++;
                    end
                end
            end

            // point transfer
            if (i_in_valid && !i_in_stall) begin
                expected_screen_q.push_back(project_point(i_in_data));
            end

            // register write, unknown indexes are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                unique case (i_cfg_index)
                    gpip_pkg::CFG_ROT_X:    rot_x_q <= i_cfg_data;
                    gpip_pkg::CFG_ROT_Y:    rot_y_q <= i_cfg_data;
                    gpip_pkg::CFG_ROT_Z:    rot_z_q <= i_cfg_data;
                    gpip_pkg::CFG_ISO:      iso_q   <= i_cfg_data;
                    gpip_pkg::CFG_DEPTH:    depth_q <= i_cfg_data[15:0];
                    gpip_pkg::CFG_ZOOM:     zoom_q  <= i_cfg_data[15:0];
                    gpip_pkg::CFG_SHIFT:    shift_q <= i_cfg_data;
                    gpip_pkg::CFG_MAP_SIZE: map_q   <= i_cfg_data[21:0];
                    default: ;
                endcase
            end
        end
        pending_cnt = expected_screen_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for the isometric projector: clock, reset, stimulus and verdict
module tb;

    localparam int GB              = gpip_pkg::GRID_BITS;
    localparam int IW              = gpip_pkg::CFG_IDX_W;
    localparam int DW              = gpip_pkg::CFG_DATA_W;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 68;

    localparam logic [IW-1:0] CFG_UNUSED_FIRST = 4'd8;
    localparam logic [IW-1:0] CFG_UNUSED_LAST  = 4'd15;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_BLOCKS} t_rx_mode;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                i_stall     = 1'b0;
    gpip_pkg::t_in_item  i_data      = '0;
    logic                i_cfg_valid = 1'b0;
    logic [IW-1:0]       i_cfg_index = '0;
    logic [DW-1:0]       i_cfg_data  = '0;
    logic                o_stall;
    logic                o_valid;
    logic                o_cfg_ready;
    gpip_pkg::t_out_item o_data;

    int       fails;
    int       pending;
    int       idle_cycles = 0;
    int       stall_tick  = 0;
    int       stall_len;
    t_rx_mode stall_mode;
    int       map_w       = 0;
    int       map_h       = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    grid_point_isometric_projector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    projector_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern; the mode is redrawn at random after each run
    always begin
        stall_mode = t_rx_mode'($urandom_range(RX_FREE, RX_BLOCKS));
        stall_len  = $urandom_range(40, 300);
        repeat (stall_len) begin
            @(negedge i_clk);
            stall_tick++;
            case (stall_mode)
                RX_FREE:     i_stall <= 1'b0;
                RX_LIGHT:    i_stall <= ($urandom_range(0, 9) < 3);
                RX_HEAVY:    i_stall <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: i_stall <= ((stall_tick % 4) == 0);
                default:     i_stall <= ((stall_tick % 40) < 25);
            endcase
        end
    end

    function automatic gpip_pkg::t_in_item mk_point(input int col, input int row, input int h);
        gpip_pkg::t_in_item pt;
        pt.grid_col = GB'(col);
        pt.grid_row = GB'(row);
        pt.height   = 16'(h);
        return pt;
    endfunction

    // signed Q2.14 value within plus or minus one
    function automatic logic [15:0] rand_q14();
        int v;
        v = $urandom_range(0, 32768);
        v = v - 16384;
        return v[15:0];
    endfunction

    function automatic logic [31:0] rand_trig();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_8000;
            1:       return 32'h7FFF_7FFF;
            2:       return 32'h0000_0000;
            3:       return 32'h8000_7FFF;
            4, 5, 6: return {rand_q14(), rand_q14()};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_reg(input logic [IW-1:0] idx);
        int sel;
        int a, b;
        sel = $urandom_range(0, 9);
        a   = $urandom_range(0, 800);
        b   = $urandom_range(0, 600);
        case (idx)
            gpip_pkg::CFG_DEPTH: begin
                if (sel < 2) return 32'h0000_8000;
                if (sel < 3) return 32'h0000_7FFF;
                if (sel < 6) return {16'h0000, rand_q14() >> 1};
                return $urandom;
            end
            gpip_pkg::CFG_ZOOM: begin
                if (sel < 1) return 32'h0000_0000;
                if (sel < 2) return 32'h0000_FFFF;
                if (sel < 6) return $urandom_range(1, 1024);
                return $urandom;
            end
            gpip_pkg::CFG_SHIFT: begin
                if (sel < 1) return 32'h7FFF_7FFF;
                if (sel < 2) return 32'h8000_8000;
                if (sel < 6) return {16'(a - 400), 16'(b - 300)};
                return $urandom;
            end
            gpip_pkg::CFG_MAP_SIZE: begin
                if (sel < 1) return 32'h0000_0000;
                if (sel < 2) return 32'h003F_FFFF;
                if (sel < 3) return {10'd0, 11'd2047, 11'd1};
                if (sel < 7) begin
                    return {10'd0, 11'($urandom_range(0, 64)), 11'($urandom_range(0, 64))};
                end
                return $urandom;
            end
            default: return rand_trig();
        endcase
    endfunction

    // points mostly inside the map, some with modest heights
    function automatic gpip_pkg::t_in_item rand_point();
        gpip_pkg::t_in_item pt;
        int                 hv;
        pt.grid_col = GB'($urandom);
        pt.grid_row = GB'($urandom);
        pt.height   = 16'($urandom);
        if ($urandom_range(0, 9) < 6) begin
            if (map_w > 0) pt.grid_col = GB'($urandom_range(0, (map_w > 1024) ? 1023 : map_w - 1));
            if (map_h > 0) pt.grid_row = GB'($urandom_range(0, (map_h > 1024) ? 1023 : map_h - 1));
            if ($urandom_range(0, 1) == 0) begin
                hv        = $urandom_range(0, 4000);
                pt.height = 16'(hv - 2000);
            end
        end
        return pt;
    endfunction

    task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gpip_pkg::CFG_MAP_SIZE) begin
            map_w = int'(val[21:11]);
            map_h = int'(val[10:0]);
        end
    endtask

    task automatic write_all(input logic [31:0] rx, input logic [31:0] ry,
                             input logic [31:0] rz, input logic [31:0] iso,
                             input logic [31:0] depth, input logic [31:0] zoom,
                             input logic [31:0] shift, input logic [31:0] map);
        write_reg(gpip_pkg::CFG_ROT_X, rx);
        write_reg(gpip_pkg::CFG_ROT_Y, ry);
        write_reg(gpip_pkg::CFG_ROT_Z, rz);
        write_reg(gpip_pkg::CFG_ISO, iso);
        write_reg(gpip_pkg::CFG_DEPTH, depth);
        write_reg(gpip_pkg::CFG_ZOOM, zoom);
        write_reg(gpip_pkg::CFG_SHIFT, shift);
        write_reg(gpip_pkg::CFG_MAP_SIZE, map);
    endtask

    task automatic close_cfg();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one point transfer; valid stays up for a following point
    task automatic send_point(input gpip_pkg::t_in_item pt);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= pt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_list(input gpip_pkg::t_in_item pts[$]);
        foreach (pts[k]) begin
            send_point(pts[k]);
            sender_gap($urandom_range(0, 3));
        end
    endtask

    // stop sending and let every expected point come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        gpip_pkg::t_in_item pts[$];
        int                 sent;
        int                 burst;
        bit                 dense;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, empty map so the centring term is always positive
        pts = '{mk_point(0, 0, 0), mk_point(1023, 1023, 0), mk_point(0, 1023, 32767),
                mk_point(1023, 0, -32768), mk_point(512, 512, -1), mk_point(1, 2, 1),
                mk_point(682, 341, 16'h5555)};
        send_list(pts);
        wait_drained();

        // plausible view: tilted, rotated, half depth, zoom two, centred screen
        write_all(32'h2D41_2D41, 32'h376D_E000, 32'h376D_2000, gpip_pkg::ISO_RESET,
                  32'h0000_0800, 32'h0000_0200, 32'h0140_00F0, {10'd0, 11'd19, 11'd11});
        close_cfg();
        pts = '{mk_point(0, 0, 0), mk_point(18, 10, 100), mk_point(9, 5, -100),
                mk_point(1023, 1023, 32767), mk_point(0, 0, -32768)};
        send_list(pts);
        wait_drained();

        // extreme settings drive saturation; unknown indexes must leave them alone
        write_all(32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000, 32'h7FFF_7FFF,
                  32'hFFFF_8000, 32'h0000_FFFF, 32'h7FFF_8000, 32'h003F_FFFF);
        write_reg(CFG_UNUSED_FIRST, 32'h0000_0000);
        write_reg(CFG_UNUSED_LAST, 32'hFFFF_FFFF);
        close_cfg();
        pts = '{mk_point(0, 0, 32767), mk_point(1023, 1023, -32768), mk_point(1023, 0, 0),
                mk_point(0, 1023, 1), mk_point(512, 512, -32768)};
        send_list(pts);
        wait_drained();

        // everything zero collapses the point to the origin
        write_all('0, '0, '0, '0, '0, '0, '0, '0);
        close_cfg();
        pts = '{mk_point(1023, 0, 32767), mk_point(5, 5, -5)};
        send_list(pts);
        wait_drained();

        // random settings, bursty random points
        repeat (RANDOM_PHASES) begin
            write_all(rand_reg(gpip_pkg::CFG_ROT_X), rand_reg(gpip_pkg::CFG_ROT_Y),
                      rand_reg(gpip_pkg::CFG_ROT_Z), rand_reg(gpip_pkg::CFG_ISO),
                      rand_reg(gpip_pkg::CFG_DEPTH), rand_reg(gpip_pkg::CFG_ZOOM),
                      rand_reg(gpip_pkg::CFG_SHIFT), rand_reg(gpip_pkg::CFG_MAP_SIZE));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_UNUSED_FIRST + IW'($urandom_range(0, 7)), $urandom);
            end
            close_cfg();
            dense = ($urandom_range(0, 2) == 0);
            sent  = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && sent < ITEMS_PER_PHASE) begin
                    send_point(rand_point());
                    sent++;
                    burst--;
                end
                if (!dense) sender_gap($urandom_range(1, 12));
            end
            wait_drained();
        end

        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
